// ----- hdl/led_bfc_pkg.sv -----
// shared types, constants and duty mapping for the led blink/fade controller
package led_bfc_pkg;

    localparam int unsigned FADE_INTERVAL_MS = 5;

    localparam logic [7:0] DUTY_MAX        = 8'd255;
    localparam logic [9:0] DUTY_SCALED_MAX = 10'd1023;
    localparam logic [9:0] DUTY_FULL_ON    = 10'd256;
    localparam logic [2:0] FADE_SHIFT_MAX  = 3'd7;
    localparam logic [7:0] BRIGHTNESS_RST  = 8'd255;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_BLINK = 2'd1,
        KIND_FADE  = 2'd2,
        KIND_OFF   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_ON   = 2'd1,
        PH_OFF  = 2'd2,
        PH_FADE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_SCALED = 2'd1,
        MODE_FULL   = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CFG_BRIGHTNESS  = 2'd0,
        CFG_ACTIVE_LOW  = 2'd1,
        CFG_OUTPUT_MODE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] on_time;
        logic [15:0] off_time;
        logic [7:0]  repeat_count;
        logic [7:0]  decay_shift;
    } in_item_t;

    typedef struct packed {
        logic [9:0] duty_out;
        logic       duty_written;
        phase_t     phase;
    } out_item_t;

    typedef struct packed {
        logic [7:0] brightness;
        logic       active_low;
        logic [1:0] output_mode;
    } cfg_t;

    function automatic logic [9:0] map_duty(
        input logic [7:0] duty,
        input logic       active_low,
        input logic [1:0] output_mode
    );
        logic [7:0] v;
        logic [9:0] m;
        v = active_low ? (DUTY_MAX - duty) : duty;
        case (output_mode)
            MODE_SCALED:
            begin
                if (v == 8'd0)
                    m = 10'd0;
                else if (v == DUTY_MAX)
                    m = DUTY_SCALED_MAX;
                else
                    m = {v, 2'b11};
            end
            MODE_FULL:
            begin
                m = (v == DUTY_MAX) ? DUTY_FULL_ON : {2'b00, v};
            end
            default:
            begin
                m = {2'b00, v};
            end
        endcase
        return m;
    endfunction

endpackage

// ----- hdl/led_bfc_cfg.sv -----
// configuration register file: brightness, active-low flag and output mode
module led_bfc_cfg (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [7:0]            cfg_data,
    output led_bfc_pkg::cfg_t     cfg
);

    led_bfc_pkg::cfg_t cfg_reg;
    led_bfc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                led_bfc_pkg::CFG_BRIGHTNESS:  cfg_next.brightness  = cfg_data;
                led_bfc_pkg::CFG_ACTIVE_LOW:  cfg_next.active_low  = cfg_data[0];
                led_bfc_pkg::CFG_OUTPUT_MODE: cfg_next.output_mode = cfg_data[1:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brightness  <= led_bfc_pkg::BRIGHTNESS_RST;
            cfg_reg.active_low  <= 1'b0;
            cfg_reg.output_mode <= led_bfc_pkg::MODE_PLAIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hdl/led_bfc_in_reg.sv -----
// input register stage holding one accepted command or tick beat
module led_bfc_in_reg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  led_bfc_pkg::in_item_t     in_item,
    input  logic                      take,
    output logic                      item_valid,
    output led_bfc_pkg::in_item_t     item
);

    logic                  valid_reg;
    logic                  valid_next;
    logic                  load;
    led_bfc_pkg::in_item_t item_reg;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= in_item;
    end

endmodule

// ----- hdl/led_bfc_seq.sv -----
// blink/fade sequencer state, duty mapping and result register
module led_bfc_seq (
    input  logic                      clk,
    input  logic                      rst_n,
    input  led_bfc_pkg::cfg_t         cfg,
    input  logic                      item_valid,
    input  led_bfc_pkg::in_item_t     item,
    output logic                      take,
    output logic                      out_valid,
    input  logic                      out_stall,
    output led_bfc_pkg::out_item_t    out_item
);

    led_bfc_pkg::phase_t phase_reg, phase_next;
    logic [31:0] time_now_reg, time_now_next;
    logic [31:0] deadline_reg, deadline_next;
    logic [7:0]  cycles_reg, cycles_next;
    logic [7:0]  level_reg, level_next;
    logic [2:0]  shift_reg, shift_next;
    logic [15:0] on_len_reg, on_len_next;
    logic [15:0] off_len_reg, off_len_next;
    logic [9:0]  duty_reg, duty_next;

    logic                    out_valid_reg, out_valid_next;
    led_bfc_pkg::out_item_t  out_reg;

    logic [31:0] now;
    logic [31:0] diff;
    logic        due;
    logic [7:0]  delta_raw;
    logic [7:0]  delta;
    logic        fade_end;
    logic [7:0]  level_dec;
    logic [7:0]  cycles_dec;
    logic        wr;
    logic [7:0]  wr_duty;

    assign take      = item_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign now        = time_now_reg + 32'd1;
    assign diff       = now - deadline_reg;
    assign due        = !diff[31];
    assign delta_raw  = level_reg >> shift_reg;
    assign delta      = (delta_raw == 8'd0) ? 8'd1 : delta_raw;
    assign fade_end   = {1'b0, level_reg} <= ({1'b0, delta} + 9'd1);
    assign level_dec  = level_reg - delta;
    assign cycles_dec = cycles_reg - 8'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        time_now_next = time_now_reg;
        deadline_next = deadline_reg;
        cycles_next   = cycles_reg;
        level_next    = level_reg;
        shift_next    = shift_reg;
        on_len_next   = on_len_reg;
        off_len_next  = off_len_reg;
        wr            = 1'b0;
        wr_duty       = 8'd0;
        if (take)
        begin
            case (item.kind)
                led_bfc_pkg::KIND_TICK:
                begin
                    time_now_next = now;
                    if (phase_reg != led_bfc_pkg::PH_IDLE && due)
                    begin
                        case (phase_reg)
                            led_bfc_pkg::PH_FADE:
                            begin
                                wr = 1'b1;
                                if (fade_end)
                                begin
                                    level_next = 8'd0;
                                    wr_duty    = 8'd0;
                                    phase_next = led_bfc_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    level_next    = level_dec;
                                    wr_duty       = level_dec;
                                    deadline_next =
                                        now + 32'(led_bfc_pkg::FADE_INTERVAL_MS);
                                end
                            end
                            led_bfc_pkg::PH_ON:
                            begin
                                wr            = 1'b1;
                                wr_duty       = 8'd0;
                                phase_next    = led_bfc_pkg::PH_OFF;
                                deadline_next = now + {16'd0, off_len_reg};
                            end
                            led_bfc_pkg::PH_OFF:
                            begin
                                cycles_next = cycles_dec;
                                if (cycles_dec == 8'd0)
                                begin
                                    phase_next = led_bfc_pkg::PH_IDLE;
                                end
                                else
                                begin
                                    wr            = 1'b1;
                                    wr_duty       = cfg.brightness;
                                    phase_next    = led_bfc_pkg::PH_ON;
                                    deadline_next = now + {16'd0, on_len_reg};
                                end
                            end
                            default:
                            begin
                                phase_next = phase_reg;
                            end
                        endcase
                    end
                end
                led_bfc_pkg::KIND_BLINK:
                begin
                    wr = 1'b1;
                    if (item.repeat_count == 8'd0)
                    begin
                        // zero count behaves as off
                        phase_next  = led_bfc_pkg::PH_IDLE;
                        cycles_next = 8'd0;
                        level_next  = 8'd0;
                        wr_duty     = 8'd0;
                    end
                    else
                    begin
                        on_len_next   = item.on_time;
                        off_len_next  = item.off_time;
                        cycles_next   = item.repeat_count;
                        wr_duty       = cfg.brightness;
                        phase_next    = led_bfc_pkg::PH_ON;
                        deadline_next = time_now_reg + {16'd0, item.on_time};
                    end
                end
                led_bfc_pkg::KIND_FADE:
                begin
                    shift_next    = (item.decay_shift[7:3] != 5'd0) ?
                                    led_bfc_pkg::FADE_SHIFT_MAX : item.decay_shift[2:0];
                    level_next    = cfg.brightness;
                    wr            = 1'b1;
                    wr_duty       = cfg.brightness;
                    phase_next    = led_bfc_pkg::PH_FADE;
                    deadline_next = time_now_reg + 32'(led_bfc_pkg::FADE_INTERVAL_MS);
                end
                default:
                begin
                    phase_next  = led_bfc_pkg::PH_IDLE;
                    cycles_next = 8'd0;
                    level_next  = 8'd0;
                    wr          = 1'b1;
                    wr_duty     = 8'd0;
                end
            endcase
        end
        duty_next = wr ? led_bfc_pkg::map_duty(wr_duty, cfg.active_low, cfg.output_mode)
                       : duty_reg;
    end

    always_comb
    begin
        if (take)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= led_bfc_pkg::PH_IDLE;
            time_now_reg  <= 32'd0;
            deadline_reg  <= 32'd0;
            cycles_reg    <= 8'd0;
            level_reg     <= 8'd0;
            shift_reg     <= 3'd0;
            on_len_reg    <= 16'd0;
            off_len_reg   <= 16'd0;
            duty_reg      <= 10'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            time_now_reg  <= time_now_next;
            deadline_reg  <= deadline_next;
            cycles_reg    <= cycles_next;
            level_reg     <= level_next;
            shift_reg     <= shift_next;
            on_len_reg    <= on_len_next;
            off_len_reg   <= off_len_next;
            duty_reg      <= duty_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg.duty_out     <= duty_next;
            out_reg.duty_written <= wr;
            out_reg.phase        <= phase_next;
        end
    end

`ifndef SYNTHESIS
    a_tick_advances_time: assert property (@(posedge clk) disable iff (!rst_n)
        take && item.kind == led_bfc_pkg::KIND_TICK
        |=> time_now_reg == $past(time_now_reg) + 32'd1)
        else $error("time counter did not advance on a tick beat");

    a_idle_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(time_now_reg) && $stable(phase_reg) && $stable(duty_reg))
        else $error("sequencer state changed without a beat");

    a_take_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> out_valid_reg)
        else $error("accepted beat produced no result");

    a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.phase == phase_reg && out_reg.duty_out == duty_reg)
        else $error("held result disagrees with sequencer state");
`endif

endmodule

// ----- hdl/led_blink_fade_controller.sv -----
// an accepted beat is held in the input register, then the sequencer step writes its result register
// throughput: one command or tick beat per cycle while the output is not stalled
// the configuration port is always ready and takes one write per cycle
// reset clears phase, time, deadline, counters and duty to zero, brightness to 255
// active_low and output_mode reset to 0; the pipeline comes out of reset empty
module led_blink_fade_controller (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  led_bfc_pkg::in_item_t     in_item,
    output logic                      out_valid,
    input  logic                      out_stall,
    output led_bfc_pkg::out_item_t    out_item,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [7:0]                cfg_data
);

    led_bfc_pkg::cfg_t     cfg;
    led_bfc_pkg::in_item_t item;
    logic                  item_valid;
    logic                  take;

    led_bfc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    led_bfc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    led_bfc_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

// ----- bench/tb_led_blink_fade_controller.sv -----
// self-checking testbench for the led blink/fade controller: directed table, bursts, predictor
module tb_led_blink_fade_controller;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 60;
    localparam int PHASE_BEATS = 240;
    localparam int DRAIN_LIMIT = 2000;
    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct {
        led_bfc_pkg::in_item_t  cmd;
        bit                     fixed;
        led_bfc_pkg::out_item_t want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    led_bfc_pkg::in_item_t  in_item = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    led_bfc_pkg::out_item_t out_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [1:0]             cfg_index = '0;
    logic [7:0]             cfg_data = '0;

    logic [7:0]          brightness = led_bfc_pkg::BRIGHTNESS_RST;
    logic                active_low = 1'b0;
    logic [1:0]          output_mode = led_bfc_pkg::MODE_PLAIN;
    led_bfc_pkg::phase_t phase_now = led_bfc_pkg::PH_IDLE;
    logic [31:0]         time_ms = '0;
    logic [31:0]         deadline = '0;
    logic [7:0]          cycles_left = '0;
    logic [7:0]          fade_level = '0;
    logic [2:0]          fade_shift = '0;
    logic [15:0]         on_len = '0;
    logic [15:0]         off_len = '0;
    logic [9:0]          duty_now = '0;
    logic                duty_wrote = 1'b0;

    led_bfc_pkg::out_item_t duty_expect_q[$];
    int errors = 0;
    int cycles = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_ticket = 0;
    int hold_served = 0;
    int hold_left = 0;
    int burst_left = 0;

    led_blink_fade_controller u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [9:0] mapped_duty(input logic [7:0] level);
        logic [7:0] v;
        v = active_low ? (8'd255 - level) : level;
        if (output_mode == led_bfc_pkg::MODE_SCALED)
        begin
            if (v == 8'd0)
                return 10'd0;
            if (v == led_bfc_pkg::DUTY_MAX)
                return led_bfc_pkg::DUTY_SCALED_MAX;
            return ({2'b00, v} << 2) + 10'd3;
        end
        if (output_mode == led_bfc_pkg::MODE_FULL && v == led_bfc_pkg::DUTY_MAX)
            return led_bfc_pkg::DUTY_FULL_ON;
        return {2'b00, v};
    endfunction

    function automatic void write_duty(input logic [7:0] level);
        duty_now = mapped_duty(level);
        duty_wrote = 1'b1;
    endfunction

    function automatic void lamp_off();
        phase_now = led_bfc_pkg::PH_IDLE;
        cycles_left = '0;
        fade_level = '0;
        write_duty(8'd0);
    endfunction

    function automatic void tick_advance();
        logic [31:0] late;
        logic [8:0]  step;
        late = time_ms - deadline;
        if (phase_now == led_bfc_pkg::PH_IDLE || late[31])
            return;
        case (phase_now)
            led_bfc_pkg::PH_FADE:
            begin
                step = {1'b0, fade_level >> fade_shift};
                if (step == 9'd0)
                    step = 9'd1;
                if ({1'b0, fade_level} <= step + 9'd1)
                begin
                    fade_level = '0;
                    write_duty(8'd0);
                    phase_now = led_bfc_pkg::PH_IDLE;
                end
                else
                begin
                    fade_level = fade_level - step[7:0];
                    write_duty(fade_level);
                    deadline = time_ms + led_bfc_pkg::FADE_INTERVAL_MS;
                end
            end
            led_bfc_pkg::PH_ON:
            begin
                write_duty(8'd0);
                phase_now = led_bfc_pkg::PH_OFF;
                deadline = time_ms + {16'd0, off_len};
            end
            default:
            begin
                cycles_left = cycles_left - 8'd1;
                if (cycles_left == 8'd0)
                    phase_now = led_bfc_pkg::PH_IDLE;
                else
                begin
                    write_duty(brightness);
                    phase_now = led_bfc_pkg::PH_ON;
                    deadline = time_ms + {16'd0, on_len};
                end
            end
        endcase
    endfunction

    function automatic led_bfc_pkg::out_item_t sequencer_step(input led_bfc_pkg::in_item_t c);
        led_bfc_pkg::out_item_t r;
        duty_wrote = 1'b0;
        case (c.kind)
            led_bfc_pkg::KIND_TICK:
            begin
                time_ms = time_ms + 32'd1;
                tick_advance();
            end
            led_bfc_pkg::KIND_BLINK:
            begin
                if (c.repeat_count == 8'd0)
                    lamp_off();
                else
                begin
                    on_len = c.on_time;
                    off_len = c.off_time;
                    cycles_left = c.repeat_count;
                    write_duty(brightness);
                    phase_now = led_bfc_pkg::PH_ON;
                    deadline = time_ms + {16'd0, c.on_time};
                end
            end
            led_bfc_pkg::KIND_FADE:
            begin
                fade_shift = (c.decay_shift > 8'd7) ? led_bfc_pkg::FADE_SHIFT_MAX
                                                    : c.decay_shift[2:0];
                fade_level = brightness;
                write_duty(fade_level);
                phase_now = led_bfc_pkg::PH_FADE;
                deadline = time_ms + led_bfc_pkg::FADE_INTERVAL_MS;
            end
            default:
            begin
                lamp_off();
            end
        endcase
        r.duty_out = duty_now;
        r.duty_written = duty_wrote;
        r.phase = phase_now;
        return r;
    endfunction

    function automatic dir_row_t dir_step(input led_bfc_pkg::kind_t k,
                                          input logic [15:0] on_t, off_t,
                                          input logic [7:0] cnt, shift,
                                          input bit fixed = 1'b0,
                                          input logic [9:0] duty = '0,
                                          input logic wr = 1'b0,
                                          input led_bfc_pkg::phase_t ph = led_bfc_pkg::PH_IDLE);
        dir_row_t d;
        d.cmd.kind = k;
        d.cmd.on_time = on_t;
        d.cmd.off_time = off_t;
        d.cmd.repeat_count = cnt;
        d.cmd.decay_shift = shift;
        d.fixed = fixed;
        d.want.duty_out = duty;
        d.want.duty_written = wr;
        d.want.phase = ph;
        return d;
    endfunction

    function automatic logic [15:0] pick_len();
        int roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return 16'($urandom_range(0, 6));
        if (roll < 95)
            return 16'($urandom_range(0, 40));
        return 16'($urandom);
    endfunction

    function automatic led_bfc_pkg::in_item_t random_cmd(input led_bfc_pkg::kind_t k);
        led_bfc_pkg::in_item_t c;
        c.kind = k;
        c.on_time = pick_len();
        c.off_time = pick_len();
        c.repeat_count = ($urandom_range(9) < 7) ? 8'($urandom_range(1, 4))
                                                 : 8'($urandom_range(0, 255));
        c.decay_shift = ($urandom_range(1) == 0) ? 8'($urandom_range(0, 7))
                                                 : 8'($urandom_range(0, 255));
        return c;
    endfunction

    task automatic push_beat(input led_bfc_pkg::in_item_t c, input bit fixed = 1'b0,
                             input led_bfc_pkg::out_item_t want = '0);
        led_bfc_pkg::out_item_t r;
        in_valid <= 1'b1;
        in_item <= c;
        do
            @(posedge clk);
        while (in_stall);
        r = sequencer_step(c);
        duty_expect_q.push_back(fixed ? want : r);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (duty_expect_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_put(input logic [1:0] idx, input logic [7:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            led_bfc_pkg::CFG_BRIGHTNESS:  brightness = data;
            led_bfc_pkg::CFG_ACTIVE_LOW:  active_low = data[0];
            led_bfc_pkg::CFG_OUTPUT_MODE: output_mode = data[1:0];
            default:                      ;
        endcase
    endtask

    task automatic load_config(input logic [7:0] bright, input logic low, input logic [1:0] mode);
        logic [7:0] low_data;
        logic [7:0] mode_data;
        low_data = 8'($urandom);
        low_data[0] = low;
        mode_data = 8'($urandom);
        mode_data[1:0] = mode;
        drain_results();
        cfg_put(led_bfc_pkg::CFG_BRIGHTNESS, bright);
        cfg_put(led_bfc_pkg::CFG_ACTIVE_LOW, low_data);
        cfg_put(led_bfc_pkg::CFG_OUTPUT_MODE, mode_data);
        cfg_put(CFG_SPARE, 8'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic run_bursts(input int beats);
        int                  sent;
        int                  roll;
        int                  ticks;
        led_bfc_pkg::kind_t  k;
        sent = 0;
        while (sent < beats)
        begin
            roll = $urandom_range(99);
            if (roll < 50)
                k = led_bfc_pkg::KIND_BLINK;
            else if (roll < 85)
                k = led_bfc_pkg::KIND_FADE;
            else if (roll < 93)
                k = led_bfc_pkg::KIND_OFF;
            else
                k = led_bfc_pkg::KIND_TICK;
            push_beat(random_cmd(k));
            sent++;
            ticks = $urandom_range(0, 40);
            while (ticks != 0 && sent < beats)
            begin
                push_beat(random_cmd(led_bfc_pkg::KIND_TICK));
                sent++;
                ticks--;
            end
        end
    endtask

    // result checker and output stall generator
    always @(posedge clk)
    begin
        led_bfc_pkg::out_item_t want;
        bit                     stall_next;
        if (rst_n && out_valid && !out_stall)
        begin
            if (duty_expect_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat duty_out=%0d duty_written=%0b phase=%0d",
                         $time, out_item.duty_out, out_item.duty_written, out_item.phase);
            end
            else
            begin
                want = duty_expect_q.pop_front();
                if (out_item.duty_out !== want.duty_out ||
                    out_item.duty_written !== want.duty_written ||
                    out_item.phase !== want.phase)
                begin
                    errors++;
                    $display("%0t: expected duty_out=%0d duty_written=%0b phase=%0d,",
                             $time, want.duty_out, want.duty_written, want.phase,
                             " got %0d %0b %0d",
                             out_item.duty_out, out_item.duty_written, out_item.phase);
                end
            end
        end
        stall_next = 1'b0;
        if (hold_ticket != hold_served)
        begin
            hold_served = hold_ticket;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            stall_next = 1'b1;
        end
        else if (burst_left != 0)
        begin
            burst_left--;
            stall_next = 1'b1;
        end
        else if (stall_pct != 0 && $urandom_range(99) < stall_pct)
        begin
            burst_left = $urandom_range(0, 4);
            stall_next = 1'b1;
        end
        out_stall <= stall_next;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        dir_row_t rows[$];
        int       wait_left;
        rows.push_back(dir_step(led_bfc_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 8'h00,
                                1'b1, 10'd0, 1'b0, led_bfc_pkg::PH_IDLE));
        rows.push_back(dir_step(led_bfc_pkg::KIND_TICK, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                                1'b1, 10'd0, 1'b0, led_bfc_pkg::PH_IDLE));
        rows.push_back(dir_step(led_bfc_pkg::KIND_OFF, 16'h0000, 16'h0000, 8'h00, 8'h00,
                                1'b1, 10'd0, 1'b1, led_bfc_pkg::PH_IDLE));
        rows.push_back(dir_step(led_bfc_pkg::KIND_BLINK, 16'h0000, 16'h0000, 8'h01, 8'h00,
                                1'b1, 10'd255, 1'b1, led_bfc_pkg::PH_ON));
        rows.push_back(dir_step(led_bfc_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 8'h00,
                                1'b1, 10'd0, 1'b1, led_bfc_pkg::PH_OFF));
        // last blink cycle ends without a duty write
        rows.push_back(dir_step(led_bfc_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 8'h00,
                                1'b1, 10'd0, 1'b0, led_bfc_pkg::PH_IDLE));
        // zero repeat count acts as off
        rows.push_back(dir_step(led_bfc_pkg::KIND_BLINK, 16'hFFFF, 16'hFFFF, 8'h00, 8'hFF,
                                1'b1, 10'd0, 1'b1, led_bfc_pkg::PH_IDLE));
        rows.push_back(dir_step(led_bfc_pkg::KIND_BLINK, 16'h0002, 16'h0001, 8'h02, 8'h00));
        repeat (6)
            rows.push_back(dir_step(led_bfc_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 8'h00));
        // shift above 7 is clamped
        rows.push_back(dir_step(led_bfc_pkg::KIND_FADE, 16'h0000, 16'h0000, 8'h00, 8'hFF,
                                1'b1, 10'd255, 1'b1, led_bfc_pkg::PH_FADE));
        rows.push_back(dir_step(led_bfc_pkg::KIND_FADE, 16'hFFFF, 16'hFFFF, 8'hFF, 8'h00,
                                1'b1, 10'd255, 1'b1, led_bfc_pkg::PH_FADE));
        // fade ends at once when the step covers the level
        repeat (5)
            rows.push_back(dir_step(led_bfc_pkg::KIND_TICK, 16'h0000, 16'h0000, 8'h00, 8'h00));
        rows.push_back(dir_step(led_bfc_pkg::KIND_BLINK, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                                1'b1, 10'd255, 1'b1, led_bfc_pkg::PH_ON));
        rows.push_back(dir_step(led_bfc_pkg::KIND_TICK, 16'hFFFF, 16'h0000, 8'h00, 8'hFF));
        rows.push_back(dir_step(led_bfc_pkg::KIND_FADE, 16'h0000, 16'h0000, 8'h00, 8'h03,
                                1'b1, 10'd255, 1'b1, led_bfc_pkg::PH_FADE));
        rows.push_back(dir_step(led_bfc_pkg::KIND_OFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF,
                                1'b1, 10'd0, 1'b1, led_bfc_pkg::PH_IDLE));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        gap_pct = 20;
        stall_pct = 20;
        foreach (rows[i])
            push_beat(rows[i].cmd, rows[i].fixed, rows[i].want);

        load_config(8'd0, 1'b0, led_bfc_pkg::MODE_PLAIN);
        run_bursts(PHASE_BEATS);

        load_config(8'd255, 1'b1, led_bfc_pkg::MODE_SCALED);
        gap_pct = 0;
        stall_pct = 0;
        run_bursts(PHASE_BEATS);

        // long output hold while the sender keeps offering beats
        load_config(8'd255, 1'b0, led_bfc_pkg::MODE_FULL);
        stall_pct = 10;
        hold_ticket++;
        run_bursts(PHASE_BEATS / 2);
        drain_results();
        hold_ticket++;
        run_bursts(PHASE_BEATS / 2);

        load_config(8'd1, 1'b1, MODE_SPARE);
        gap_pct = 40;
        stall_pct = 40;
        run_bursts(PHASE_BEATS);

        load_config(8'd254, 1'b0, led_bfc_pkg::MODE_SCALED);
        gap_pct = 15;
        stall_pct = 30;
        run_bursts(PHASE_BEATS);

        gap_pct = 0;
        stall_pct = 0;
        load_config(8'($urandom), 1'($urandom), 2'($urandom_range(0, 3)));
        run_bursts(PHASE_BEATS);

        in_valid <= 1'b0;
        wait_left = DRAIN_LIMIT;
        while (duty_expect_q.size() != 0 && wait_left != 0)
        begin
            @(posedge clk);
            wait_left--;
        end
        repeat (4) @(posedge clk);
        if (duty_expect_q.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected beats never arrived", $time, duty_expect_q.size());
        end
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
